FILE: hw/rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Types and constants shared by the battery power supervisor files.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned MV_W    = 14;
  localparam int unsigned TEMP_W  = 8;
  localparam int unsigned RISE_W  = 7;
  localparam int unsigned DELAY_W = 8;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET_RUN    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD_CAM   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SET_HEATER = 2'd3;

  // supply commands
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ON   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_OFF  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SHED_THR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEATER_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLD_THR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RISE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_PER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHED_DELAY  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REBOOT_LIM  = 3'd7;

  // register reset values
  localparam logic [MV_W-1:0]          RST_SHED_THR    = 14'd3200;
  localparam logic [MV_W-1:0]          RST_RECOVER_THR = 14'd3400;
  localparam logic [MV_W-1:0]          RST_HEATER_THR  = 14'd3500;
  localparam logic signed [TEMP_W-1:0] RST_COLD_THR    = -8'sd10;
  localparam logic [RISE_W-1:0]        RST_MIN_RISE    = 7'd3;
  localparam logic [RISE_W-1:0]        RST_CHECK_PER   = 7'd30;
  localparam logic [DELAY_W-1:0]       RST_SHED_DELAY  = 8'd10;
  localparam logic [COUNT_W-1:0]       RST_REBOOT_LIM  = 16'd9000;

  typedef struct packed {
    logic [MV_W-1:0]          shed_thr;
    logic [MV_W-1:0]          recover_thr;
    logic [MV_W-1:0]          heater_thr;
    logic signed [TEMP_W-1:0] cold_thr;
    logic [RISE_W-1:0]        min_rise;
    logic [RISE_W-1:0]        check_period;
    logic [DELAY_W-1:0]       shed_delay;
    logic [COUNT_W-1:0]       reboot_limit;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [MV_W-1:0]          cell_low_mv;
    logic [MV_W-1:0]          cell_high_mv;
    logic signed [TEMP_W-1:0] battery_temp_c;
    logic                     heater_sense;
    logic [COUNT_W-1:0]       set_value;
  } item_t;

  // supervisor state, watchdog phase excepted
  typedef struct packed {
    logic [DELAY_W-1:0]       shed_counter;
    logic [COUNT_W-1:0]       camera_countdown;
    logic                     computer_run;
    logic                     heater_first;
    logic [RISE_W-1:0]        heater_countdown;
    logic signed [TEMP_W-1:0] temp_baseline;
    logic                     heater_valid;
    logic [COUNT_W-1:0]       elapsed_ticks;
  } state_t;

  typedef struct packed {
    logic               computer_power;
    logic [CMD_W-1:0]   radio_power_cmd;
    logic               camera_off;
    logic [CMD_W-1:0]   heater_cmd;
    logic               watchdog_feed;
    logic               heater_fault;
    logic               heater_enabled;
    logic               reboot_request;
    logic [COUNT_W-1:0] tick_count;
  } result_t;

endpackage

FILE: hw/rtl/bps_in_if.sv
// ----------------------------------------------------------------------------
// bps_in_if
// Request channel carrying one supervisor input item.
// ----------------------------------------------------------------------------
interface bps_in_if;
  logic                               valid;
  logic                               ready;
  logic [bps_pkg::KIND_W-1:0]         kind;
  logic [bps_pkg::MV_W-1:0]           cell_low_mv;
  logic [bps_pkg::MV_W-1:0]           cell_high_mv;
  logic signed [bps_pkg::TEMP_W-1:0]  battery_temp_c;
  logic                               heater_sense;
  logic [bps_pkg::COUNT_W-1:0]        set_value;

  modport source (output valid, kind, cell_low_mv, cell_high_mv, battery_temp_c,
                  heater_sense, set_value, input ready);
  modport sink   (input valid, kind, cell_low_mv, cell_high_mv, battery_temp_c,
                  heater_sense, set_value, output ready);
endinterface

FILE: hw/rtl/bps_out_if.sv
// ----------------------------------------------------------------------------
// bps_out_if
// Result channel carrying one supervisor result item.
// ----------------------------------------------------------------------------
interface bps_out_if;
  logic                         valid;
  logic                         ready;
  logic                         computer_power;
  logic [bps_pkg::CMD_W-1:0]    radio_power_cmd;
  logic                         camera_off;
  logic [bps_pkg::CMD_W-1:0]    heater_cmd;
  logic                         watchdog_feed;
  logic                         heater_fault;
  logic                         heater_enabled;
  logic                         reboot_request;
  logic [bps_pkg::COUNT_W-1:0]  tick_count;

  modport source (output valid, computer_power, radio_power_cmd, camera_off, heater_cmd,
                  watchdog_feed, heater_fault, heater_enabled, reboot_request,
                  tick_count, input ready);
  modport sink   (input valid, computer_power, radio_power_cmd, camera_off, heater_cmd,
                  watchdog_feed, heater_fault, heater_enabled, reboot_request,
                  tick_count, output ready);
endinterface

FILE: hw/rtl/bps_cfg_if.sv
// ----------------------------------------------------------------------------
// bps_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bps_pkg::CFG_IDX_W-1:0]   index;
  logic [bps_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/bps_step.sv
// ----------------------------------------------------------------------------
// bps_step
// Next-state and result logic for one supervisor request.
// ----------------------------------------------------------------------------
module bps_step #(
  parameter int unsigned WATCHDOG_PERIOD = 8,
  parameter int unsigned PHASE_W = 3
) (
  input  bps_pkg::cfg_t     cfg,
  input  bps_pkg::item_t    item,
  input  bps_pkg::state_t   state,
  input  logic [PHASE_W-1:0] phase,
  output bps_pkg::state_t   state_nxt,
  output logic [PHASE_W-1:0] phase_nxt,
  output bps_pkg::result_t  result
);

  localparam logic [PHASE_W:0] PERIOD = (PHASE_W+1)'(WATCHDOG_PERIOD);
  localparam logic [bps_pkg::DELAY_W-1:0] SHED_MAX = '1;
  localparam logic [bps_pkg::COUNT_W-1:0] TICK_MAX = '1;

  logic signed [bps_pkg::MV_W+1:0] vtop;
  logic signed [bps_pkg::MV_W+1:0] vlow;
  logic signed [bps_pkg::MV_W+1:0] shed_s, rec_s, hon_s;
  logic                            low_v, rec_v, hon_ok, below_rec;
  logic [bps_pkg::DELAY_W-1:0]     shed_cnt;
  logic [PHASE_W:0]                phase_inc;
  logic                            feed;
  logic                            cold;
  logic [bps_pkg::RISE_W-1:0]      hcd_a, hcd_b;
  logic signed [bps_pkg::TEMP_W-1:0] base_a;
  logic signed [bps_pkg::TEMP_W:0] rise;
  logic [bps_pkg::COUNT_W-1:0]     ticks_inc;

  always_comb begin
    vlow   = $signed({2'b00, item.cell_low_mv});
    vtop   = $signed({2'b00, item.cell_high_mv}) - vlow;
    shed_s = $signed({2'b00, cfg.shed_thr});
    rec_s  = $signed({2'b00, cfg.recover_thr});
    hon_s  = $signed({2'b00, cfg.heater_thr});

    low_v     = (vtop < shed_s) || (vlow < shed_s);
    rec_v     = (vtop > rec_s) && (vlow > rec_s);
    hon_ok    = (vtop > hon_s) && (vlow > hon_s);
    below_rec = (vtop < rec_s) && (vlow < rec_s);
    cold      = item.battery_temp_c < cfg.cold_thr;

    phase_inc = {1'b0, phase} + 1'b1;
    feed      = phase_inc >= PERIOD;

    state_nxt = state;
    phase_nxt = phase;
    result    = '0;
    result.tick_count = state.elapsed_ticks;
    shed_cnt  = state.shed_counter;
    hcd_a     = state.heater_countdown;
    hcd_b     = state.heater_countdown;
    base_a    = state.temp_baseline;
    rise      = '0;
    ticks_inc = state.elapsed_ticks;

    unique case (item.kind)
      bps_pkg::KIND_SET_RUN: begin
        state_nxt.computer_run = item.set_value != '0;
      end
      bps_pkg::KIND_LOAD_CAM: begin
        state_nxt.camera_countdown = item.set_value;
      end
      bps_pkg::KIND_SET_HEATER: begin
        state_nxt.heater_valid = item.set_value != '0;
      end
      default: begin
        // load shedding with hysteresis
        if (low_v) begin
          if (shed_cnt != SHED_MAX) shed_cnt = shed_cnt + 1'b1;
          if (shed_cnt >= cfg.shed_delay) begin
            result.camera_off      = 1'b1;
            result.radio_power_cmd = bps_pkg::CMD_OFF;
            state_nxt.computer_run = 1'b0;
          end
        end else if (rec_v) begin
          shed_cnt               = '0;
          result.radio_power_cmd = bps_pkg::CMD_ON;
        end
        state_nxt.shed_counter = shed_cnt;

        if (state.camera_countdown == '0) result.camera_off = 1'b1;
        else state_nxt.camera_countdown = state.camera_countdown - 1'b1;

        phase_nxt = phase_inc[PHASE_W-1:0];
        if (feed) begin
          phase_nxt            = '0;
          result.watchdog_feed = 1'b1;
          if (cold && state.heater_valid) begin
            if (hon_ok) begin
              result.heater_cmd = bps_pkg::CMD_ON;
              if (state.heater_first) begin
                base_a = item.battery_temp_c;
                hcd_a  = cfg.check_period;
                state_nxt.heater_first = 1'b0;
              end
              hcd_b = (hcd_a != '0) ? hcd_a - 1'b1 : hcd_a;
            end else if (below_rec) begin
              result.heater_cmd      = bps_pkg::CMD_OFF;
              state_nxt.heater_first = 1'b1;
              hcd_b                  = cfg.check_period;
            end
            state_nxt.heater_countdown = hcd_b;
            state_nxt.temp_baseline    = base_a;
            rise = {item.battery_temp_c[bps_pkg::TEMP_W-1], item.battery_temp_c}
                 - {base_a[bps_pkg::TEMP_W-1], base_a};
            // rise check at the end of each period while the heater draws
            if (item.heater_sense && hcd_b == '0) begin
              if (rise < $signed({2'b00, cfg.min_rise})) begin
                result.heater_cmd      = bps_pkg::CMD_OFF;
                result.heater_fault    = 1'b1;
                state_nxt.heater_valid = 1'b0;
              end else begin
                state_nxt.heater_countdown = cfg.check_period;
                state_nxt.temp_baseline    = item.battery_temp_c;
              end
            end
          end else begin
            result.heater_cmd = bps_pkg::CMD_OFF;
          end
        end

        if (ticks_inc != TICK_MAX) ticks_inc = ticks_inc + 1'b1;
        state_nxt.elapsed_ticks = ticks_inc;
        result.reboot_request   = ticks_inc > cfg.reboot_limit;
      end
    endcase

    result.computer_power = state_nxt.computer_run;
    result.heater_enabled = state_nxt.heater_valid;
  end

endmodule

FILE: hw/rtl/battery_power_supervisor.sv
// ----------------------------------------------------------------------------
// battery_power_supervisor
// Tick-driven load shedding, camera timer, watchdog feed and heater control.
// ----------------------------------------------------------------------------
// Channel   Dir  Carries
// in_ch     in   kind, cell_low_mv, cell_high_mv, battery_temp_c, heater_sense,
//                set_value
// out_ch    out  computer_power, radio_power_cmd, camera_off, heater_cmd,
//                watchdog_feed, heater_fault, heater_enabled, reboot_request,
//                tick_count
// cfg_ch    in   index, data (register write, always ready)
//
// One request per cycle sustained unless the result stalls; the result is
// valid once its request passes the input register, then the result register.
// The supervisor state advances as a request moves from the input register
// into the result register, so back-to-back requests see each other's effect.
// A stalled result holds both stages; the input register refills as soon as
// the result moves on. Reset restores register defaults and all state values.
// ----------------------------------------------------------------------------
module battery_power_supervisor #(
  parameter int unsigned WATCHDOG_PERIOD = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  bps_in_if.sink       in_ch,
  bps_out_if.source    out_ch,
  bps_cfg_if.sink      cfg_ch
);

  localparam int unsigned PHASE_W =
    (WATCHDOG_PERIOD > 1) ? $clog2(WATCHDOG_PERIOD) : 1;

  bps_pkg::cfg_t    cfg_r;
  bps_pkg::item_t   item_r;
  logic             item_valid_r;
  bps_pkg::state_t  state_r, state_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  bps_pkg::result_t result_r, result_nxt;
  logic             result_valid_r;
  logic             advance;
  logic             in_take;

  assign advance  = !result_valid_r || out_ch.ready;
  assign in_ch.ready = !item_valid_r || advance;
  assign in_take  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shed_thr     <= bps_pkg::RST_SHED_THR;
      cfg_r.recover_thr  <= bps_pkg::RST_RECOVER_THR;
      cfg_r.heater_thr   <= bps_pkg::RST_HEATER_THR;
      cfg_r.cold_thr     <= bps_pkg::RST_COLD_THR;
      cfg_r.min_rise     <= bps_pkg::RST_MIN_RISE;
      cfg_r.check_period <= bps_pkg::RST_CHECK_PER;
      cfg_r.shed_delay   <= bps_pkg::RST_SHED_DELAY;
      cfg_r.reboot_limit <= bps_pkg::RST_REBOOT_LIM;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        bps_pkg::REG_SHED_THR:    cfg_r.shed_thr     <= cfg_ch.data[bps_pkg::MV_W-1:0];
        bps_pkg::REG_RECOVER_THR: cfg_r.recover_thr  <= cfg_ch.data[bps_pkg::MV_W-1:0];
        bps_pkg::REG_HEATER_THR:  cfg_r.heater_thr   <= cfg_ch.data[bps_pkg::MV_W-1:0];
        bps_pkg::REG_COLD_THR:    cfg_r.cold_thr     <= $signed(cfg_ch.data[bps_pkg::TEMP_W-1:0]);
        bps_pkg::REG_MIN_RISE:    cfg_r.min_rise     <= cfg_ch.data[bps_pkg::RISE_W-1:0];
        bps_pkg::REG_CHECK_PER:   cfg_r.check_period <= cfg_ch.data[bps_pkg::RISE_W-1:0];
        bps_pkg::REG_SHED_DELAY:  cfg_r.shed_delay   <= cfg_ch.data[bps_pkg::DELAY_W-1:0];
        bps_pkg::REG_REBOOT_LIM:  cfg_r.reboot_limit <= cfg_ch.data[bps_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.kind           <= in_ch.kind;
      item_r.cell_low_mv    <= in_ch.cell_low_mv;
      item_r.cell_high_mv   <= in_ch.cell_high_mv;
      item_r.battery_temp_c <= in_ch.battery_temp_c;
      item_r.heater_sense   <= in_ch.heater_sense;
      item_r.set_value      <= in_ch.set_value;
    end
  end

  bps_step #(
    .WATCHDOG_PERIOD(WATCHDOG_PERIOD),
    .PHASE_W        (PHASE_W)
  ) u_step (
    .cfg      (cfg_r),
    .item     (item_r),
    .state    (state_r),
    .phase    (phase_r),
    .state_nxt(state_nxt),
    .phase_nxt(phase_nxt),
    .result   (result_nxt)
  );

  // state and result register: advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.shed_counter     <= '0;
      state_r.camera_countdown <= '0;
      state_r.computer_run     <= 1'b0;
      state_r.heater_first     <= 1'b1;
      state_r.heater_countdown <= '0;
      state_r.temp_baseline    <= '0;
      state_r.heater_valid     <= 1'b1;
      state_r.elapsed_ticks    <= '0;
      phase_r                  <= '0;
      result_valid_r           <= 1'b0;
    end else if (advance) begin
      result_valid_r <= item_valid_r;
      if (item_valid_r) begin
        state_r <= state_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_ch.valid           = result_valid_r;
  assign out_ch.computer_power  = result_r.computer_power;
  assign out_ch.radio_power_cmd = result_r.radio_power_cmd;
  assign out_ch.camera_off      = result_r.camera_off;
  assign out_ch.heater_cmd      = result_r.heater_cmd;
  assign out_ch.watchdog_feed   = result_r.watchdog_feed;
  assign out_ch.heater_fault    = result_r.heater_fault;
  assign out_ch.heater_enabled  = result_r.heater_enabled;
  assign out_ch.reboot_request  = result_r.reboot_request;
  assign out_ch.tick_count      = result_r.tick_count;

endmodule

FILE: bench/tb_battery_power_supervisor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_battery_power_supervisor
// Self-checking bench: a scripted opening, then random request streams under
// several register settings and flow-control patterns. Every result is
// compared field by field against an in-bench model or a pinned script row.
// ----------------------------------------------------------------------------
module tb_battery_power_supervisor;
  import bps_pkg::*;

  localparam int WD_PERIOD = 8;
  localparam int MV_MAX    = 16383;

  typedef struct {
    item_t   stim;
    bit      pinned;
    result_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  bps_in_if  in_ch ();
  bps_out_if out_ch ();
  bps_cfg_if cfg_ch ();

  battery_power_supervisor #(.WATCHDOG_PERIOD(WD_PERIOD)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state and register copy
  cfg_t        regs;
  logic [7:0]  shed_cnt   = '0;
  logic [15:0] cam_cnt    = '0;
  bit          run_flag   = 1'b0;
  int          wd_phase   = 0;
  bit          heat_first = 1'b1;
  logic [6:0]  heat_cnt   = '0;
  int          baseline   = 0;
  bit          heater_ok  = 1'b1;
  logic [15:0] ticks      = '0;

  result_t pending_results [$];
  row_t    pin_q [$];

  int send_idle = 0;
  int stall_pct = 0;
  int volt_mode = 2;
  int cur_temp  = -20;

  int mismatches = 0;
  int checked    = 0;
  int n_ticks    = 0;
  int n_shed     = 0;
  int n_faults   = 0;
  int n_reboot   = 0;
  int n_cam_off  = 0;

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic result_t supervise(item_t it);
    int      vlow, vtop, temp, shed_t, rec_t, hon_t;
    result_t r;
    r = '0;
    r.tick_count = ticks;
    if (it.kind == KIND_SET_RUN) begin
      run_flag = (it.set_value != 0);
    end else if (it.kind == KIND_LOAD_CAM) begin
      cam_cnt = it.set_value;
    end else if (it.kind == KIND_SET_HEATER) begin
      heater_ok = (it.set_value != 0);
    end else begin
      vlow   = int'(it.cell_low_mv);
      vtop   = int'(it.cell_high_mv) - vlow;
      temp   = int'($signed(it.battery_temp_c));
      shed_t = int'(regs.shed_thr);
      rec_t  = int'(regs.recover_thr);
      hon_t  = int'(regs.heater_thr);
      if (vtop < shed_t || vlow < shed_t) begin
        if (shed_cnt != 8'hFF) shed_cnt++;
        if (shed_cnt >= regs.shed_delay) begin
          r.camera_off      = 1'b1;
          r.radio_power_cmd = CMD_OFF;
          run_flag          = 1'b0;
        end
      end else if (vtop > rec_t && vlow > rec_t) begin
        shed_cnt          = '0;
        r.radio_power_cmd = CMD_ON;
      end
      if (cam_cnt == 0) r.camera_off = 1'b1;
      else cam_cnt--;
      wd_phase++;
      if (wd_phase >= WD_PERIOD) begin
        wd_phase        = 0;
        r.watchdog_feed = 1'b1;
        if (temp < int'($signed(regs.cold_thr)) && heater_ok) begin
          if (vtop > hon_t && vlow > hon_t) begin
            r.heater_cmd = CMD_ON;
            if (heat_first) begin
              baseline   = temp;
              heat_cnt   = regs.check_period;
              heat_first = 1'b0;
            end
            if (heat_cnt > 0) heat_cnt--;
          end else if (vtop < rec_t && vlow < rec_t) begin
            r.heater_cmd = CMD_OFF;
            heat_first   = 1'b1;
            heat_cnt     = regs.check_period;
          end
          if (it.heater_sense && heat_cnt == 0) begin
            if (temp - baseline < int'(regs.min_rise)) begin
              r.heater_cmd   = CMD_OFF;
              r.heater_fault = 1'b1;
              heater_ok      = 1'b0;
            end else begin
              heat_cnt = regs.check_period;
              baseline = temp;
            end
          end
        end else begin
          r.heater_cmd = CMD_OFF;
        end
      end
      if (ticks != 16'hFFFF) ticks++;
      if (ticks > regs.reboot_limit) r.reboot_request = 1'b1;
    end
    r.computer_power = run_flag;
    r.heater_enabled = heater_ok;
    return r;
  endfunction

  // cell voltage steered by the current regime: low, mid-band or healthy
  function automatic int pick_mv();
    int shed_t, rec_t, hon_t, lo_t, hi_t, v;
    shed_t = int'(regs.shed_thr);
    rec_t  = int'(regs.recover_thr);
    hon_t  = int'(regs.heater_thr);
    lo_t   = (shed_t < rec_t) ? shed_t : rec_t;
    lo_t   = (hon_t < lo_t) ? hon_t : lo_t;
    hi_t   = (shed_t > rec_t) ? shed_t : rec_t;
    hi_t   = (hon_t > hi_t) ? hon_t : hi_t;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(2))
        0:       v = shed_t;
        1:       v = rec_t;
        default: v = hon_t;
      endcase
      v = v + int'($urandom_range(2)) - 1;
    end else begin
      case (volt_mode)
        0:       v = shed_t - int'($urandom_range(1, 300));
        1:       v = lo_t + int'($urandom_range(0, hi_t - lo_t));
        default: v = hi_t + int'($urandom_range(1, 300));
      endcase
    end
    return clamp(v, 0, MV_MAX);
  endfunction

  function automatic item_t make_item();
    item_t it;
    int    roll, vlow_i;
    roll              = $urandom_range(99);
    it.kind           = (roll < 82) ? KIND_TICK : (roll < 88) ? KIND_SET_RUN :
                        (roll < 94) ? KIND_LOAD_CAM : KIND_SET_HEATER;
    it.cell_low_mv    = 14'($urandom);
    it.cell_high_mv   = 14'($urandom);
    it.battery_temp_c = 8'($urandom);
    it.heater_sense   = 1'($urandom_range(1));
    it.set_value      = 16'($urandom);
    case (it.kind)
      KIND_SET_RUN:
        if ($urandom_range(3) != 0) it.set_value = 16'($urandom_range(1));
      KIND_LOAD_CAM:
        if ($urandom_range(4) != 0) it.set_value = 16'($urandom_range(0, 24));
      KIND_SET_HEATER:
        if ($urandom_range(3) == 0) it.set_value = '0;
      default: begin
        if ($urandom_range(11) == 0) volt_mode = $urandom_range(2);
        if ($urandom_range(9) != 0) begin
          vlow_i          = pick_mv();
          it.cell_low_mv  = 14'(vlow_i);
          it.cell_high_mv = 14'(clamp(vlow_i + pick_mv(), 0, MV_MAX));
        end
        // drift mostly upwards, drop back below the cold line now and then
        if ($urandom_range(11) == 0)
          cur_temp = int'($signed(regs.cold_thr)) - int'($urandom_range(1, 30));
        else
          cur_temp = cur_temp + int'($urandom_range(3)) - 1;
        cur_temp = clamp(cur_temp, -128, 127);
        if ($urandom_range(12) != 0) it.battery_temp_c = 8'(cur_temp);
      end
    endcase
    return it;
  endfunction

  task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  result_t want, got;
  item_t   seen;
  row_t    pin;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_SHED_THR:    regs.shed_thr     = cfg_ch.data[MV_W-1:0];
          REG_RECOVER_THR: regs.recover_thr  = cfg_ch.data[MV_W-1:0];
          REG_HEATER_THR:  regs.heater_thr   = cfg_ch.data[MV_W-1:0];
          REG_COLD_THR:    regs.cold_thr     = cfg_ch.data[TEMP_W-1:0];
          REG_MIN_RISE:    regs.min_rise     = cfg_ch.data[RISE_W-1:0];
          REG_CHECK_PER:   regs.check_period = cfg_ch.data[RISE_W-1:0];
          REG_SHED_DELAY:  regs.shed_delay   = cfg_ch.data[DELAY_W-1:0];
          REG_REBOOT_LIM:  regs.reboot_limit = cfg_ch.data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected, tick_count %0d", out_ch.tick_count);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("computer_power",  want.computer_power,  out_ch.computer_power);
          check_field("radio_power_cmd", want.radio_power_cmd, out_ch.radio_power_cmd);
          check_field("camera_off",      want.camera_off,      out_ch.camera_off);
          check_field("heater_cmd",      want.heater_cmd,      out_ch.heater_cmd);
          check_field("watchdog_feed",   want.watchdog_feed,   out_ch.watchdog_feed);
          check_field("heater_fault",    want.heater_fault,    out_ch.heater_fault);
          check_field("heater_enabled",  want.heater_enabled,  out_ch.heater_enabled);
          check_field("reboot_request",  want.reboot_request,  out_ch.reboot_request);
          check_field("tick_count",      want.tick_count,      out_ch.tick_count);
          checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen = '{in_ch.kind, in_ch.cell_low_mv, in_ch.cell_high_mv, in_ch.battery_temp_c,
                 in_ch.heater_sense, in_ch.set_value};
        got  = supervise(seen);
        pin  = pin_q.pop_front();
        if (pin.pinned) got = pin.want;
        if (seen.kind == KIND_TICK) n_ticks++;
        if (got.radio_power_cmd == CMD_OFF) n_shed++;
        if (got.camera_off) n_cam_off++;
        if (got.heater_fault) n_faults++;
        if (got.reboot_request) n_reboot++;
        pending_results.push_back(got);
      end
    end
  end

  task automatic send_item(row_t r);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pin_q.push_back(r);
    in_ch.valid          <= 1'b1;
    in_ch.kind           <= r.stim.kind;
    in_ch.cell_low_mv    <= r.stim.cell_low_mv;
    in_ch.cell_high_mv   <= r.stim.cell_high_mv;
    in_ch.battery_temp_c <= r.stim.battery_temp_c;
    in_ch.heater_sense   <= r.stim.heater_sense;
    in_ch.set_value      <= r.stim.set_value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold the sender until every outstanding request has produced its result
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value, int width);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= 16'($urandom << width) | value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_config(cfg_t c);
    write_reg(REG_SHED_THR,    16'(c.shed_thr),       MV_W);
    write_reg(REG_RECOVER_THR, 16'(c.recover_thr),    MV_W);
    write_reg(REG_HEATER_THR,  16'(c.heater_thr),     MV_W);
    write_reg(REG_COLD_THR,    {8'h00, c.cold_thr},   TEMP_W);
    write_reg(REG_MIN_RISE,    16'(c.min_rise),       RISE_W);
    write_reg(REG_CHECK_PER,   16'(c.check_period),   RISE_W);
    write_reg(REG_SHED_DELAY,  16'(c.shed_delay),     DELAY_W);
    write_reg(REG_REBOOT_LIM,  c.reboot_limit,        COUNT_W);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(int count, int idle, int stall, bit ticks_only, bit pause_mid);
    row_t r;
    r.pinned  = 1'b0;
    r.want    = '0;
    send_idle = idle;
    stall_pct = stall;
    for (int k = 0; k < count; k++) begin
      r.stim = make_item();
      if (ticks_only) r.stim.kind = KIND_TICK;
      if (pause_mid && k == count / 2) drain();
      send_item(r);
    end
    drain();
  endtask

  // opening script under reset register values; pinned rows are read straight off
  row_t script [20] = '{
    '{'{KIND_TICK, 14'd3700, 14'd7400, 8'sd20, 1'b0, 16'd0}, 1'b1,
      '{1'b0, CMD_ON, 1'b1, CMD_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0}},
    '{'{KIND_SET_RUN, 14'd0, 14'd0, 8'sd0, 1'b0, 16'hFFFF}, 1'b1,
      '{1'b1, CMD_NONE, 1'b0, CMD_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 16'd1}},
    '{'{KIND_LOAD_CAM, 14'd16383, 14'd16383, -8'sd128, 1'b1, 16'hFFFF}, 1'b1,
      '{1'b1, CMD_NONE, 1'b0, CMD_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 16'd1}},
    '{'{KIND_SET_HEATER, 14'd0, 14'd0, 8'sd0, 1'b0, 16'd0}, 1'b1,
      '{1'b1, CMD_NONE, 1'b0, CMD_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 16'd1}},
    '{'{KIND_SET_HEATER, 14'd0, 14'd0, 8'sd0, 1'b0, 16'd1}, 1'b1,
      '{1'b1, CMD_NONE, 1'b0, CMD_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 16'd1}},
    '{'{KIND_TICK, 14'd0, 14'd0, 8'sd0, 1'b0, 16'd0}, 1'b1,
      '{1'b1, CMD_NONE, 1'b0, CMD_NONE, 1'b0, 1'b0, 1'b1, 1'b0, 16'd1}},
    '{'{KIND_TICK, 14'd16383, 14'd0, -8'sd128, 1'b1, 16'hFFFF}, 1'b0, '0},
    '{'{KIND_TICK, 14'd16383, 14'd16383, 8'sd127, 1'b1, 16'd0}, 1'b0, '0},
    '{'{KIND_TICK, 14'd3700, 14'd7400, -8'sd128, 1'b0, 16'd0}, 1'b0, '0},
    '{'{KIND_TICK, 14'd3700, 14'd7400, -8'sd128, 1'b1, 16'd0}, 1'b0, '0},
    '{'{KIND_TICK, 14'd3700, 14'd7400, -8'sd128, 1'b0, 16'd0}, 1'b0, '0},
    '{'{KIND_TICK, 14'd3700, 14'd7400, -8'sd128, 1'b0, 16'd0}, 1'b0, '0},
    '{'{KIND_SET_RUN, 14'd0, 14'd0, 8'sd0, 1'b0, 16'd0}, 1'b0, '0},
    '{'{KIND_LOAD_CAM, 14'd0, 14'd0, 8'sd0, 1'b0, 16'd1}, 1'b0, '0},
    '{'{KIND_TICK, 14'd3450, 14'd6900, -8'sd40, 1'b1, 16'd0}, 1'b0, '0},
    '{'{KIND_LOAD_CAM, 14'd0, 14'd0, 8'sd0, 1'b0, 16'd0}, 1'b0, '0},
    '{'{KIND_TICK, 14'd3300, 14'd6600, 8'sd5, 1'b1, 16'd0}, 1'b0, '0},
    '{'{KIND_SET_HEATER, 14'd0, 14'd0, 8'sd0, 1'b0, 16'h8000}, 1'b0, '0},
    '{'{KIND_SET_RUN, 14'd0, 14'd0, 8'sd0, 1'b0, 16'h0001}, 1'b0, '0},
    '{'{KIND_TICK, 14'd16383, 14'd16383, -8'sd1, 1'b1, 16'hFFFF}, 1'b0, '0}
  };

  initial begin
    regs = '{RST_SHED_THR, RST_RECOVER_THR, RST_HEATER_THR, RST_COLD_THR,
             RST_MIN_RISE, RST_CHECK_PER, RST_SHED_DELAY, RST_REBOOT_LIM};
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.kind           = KIND_TICK;
    in_ch.cell_low_mv    = '0;
    in_ch.cell_high_mv   = '0;
    in_ch.battery_temp_c = '0;
    in_ch.heater_sense   = 1'b0;
    in_ch.set_value      = '0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_SHED_THR;
    cfg_ch.data          = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) send_item(script[i]);
    run_phase(60, 0, 0, 1'b0, 1'b0);

    // quick heater checks, short shed delay, low reboot limit
    set_config('{14'd3200, 14'd3400, 14'd3500, 8'sd127, 7'd2, 7'd1, 8'd1, 16'd600});
    run_phase(100, 71, 0, 1'b0, 1'b1);

    // all registers at their floor but the reboot limit, which is 1
    set_config('{14'd0, 14'd0, 14'd0, -8'sd128, 7'd0, 7'd0, 8'd0, 16'd1});
    run_phase(100, 0, 71, 1'b0, 1'b0);

    // all registers at their ceiling; every tick low, so the shed counter pins
    set_config('{14'd16383, 14'd16383, 14'd16383, 8'sd127, 7'd127, 7'd127, 8'd255,
                 16'd65535});
    run_phase(260, 11, 11, 1'b1, 1'b0);

    set_config('{14'($urandom), 14'($urandom), 14'($urandom), 8'($urandom),
                 7'($urandom), 7'($urandom), 8'($urandom), 16'($urandom)});
    run_phase(60, $urandom_range(71), $urandom_range(71), 1'b0, 1'b0);

    set_config('{14'd3000, 14'd3300, 14'd3600, 8'sd0, 7'd1, 7'd2, 8'd3, 16'd65535});
    run_phase(60, 0, 0, 1'b0, 1'b0);

    // tick run with the count already past a low limit: reboot stays requested
    set_config('{14'd3200, 14'd3400, 14'd3500, -8'sd10, 7'd3, 7'd4, 8'd10, 16'd500});
    run_phase(90, 0, 0, 1'b1, 1'b0);

    repeat (4) @(posedge clk);
    $display("Checked %0d results over %0d ticks under seven register settings.",
             checked, n_ticks);
    $display("Seen: %0d shed commands, %0d camera-off pulses, %0d heater faults, %0d reboots.",
             n_shed, n_cam_off, n_faults, n_reboot);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bps_pkg.sv
hw/rtl/bps_in_if.sv
hw/rtl/bps_out_if.sv
hw/rtl/bps_cfg_if.sv
hw/rtl/bps_step.sv
hw/rtl/battery_power_supervisor.sv
bench/tb_battery_power_supervisor.sv
